FILE: design/pfps_pkg.sv
`default_nettype none
package pfps_pkg;

	// datapath width of the shared unit
	localparam int UW = 128;

	// shared unit operations
	localparam logic [1:0] OP_MUL  = 2'd0;
	localparam logic [1:0] OP_DIV  = 2'd1;
	localparam logic [1:0] OP_SQRT = 2'd2;

	// register indexes
	localparam logic [2:0] CFG_TARGET_X = 3'd0;
	localparam logic [2:0] CFG_TARGET_Y = 3'd1;
	localparam logic [2:0] CFG_RADIUS   = 3'd2;
	localparam logic [2:0] CFG_KA       = 3'd3;
	localparam logic [2:0] CFG_KR       = 3'd4;
	localparam logic [2:0] CFG_OBS0     = 3'd5;
	localparam logic [2:0] CFG_OBS1     = 3'd6;
	localparam logic [2:0] CFG_OBS2     = 3'd7;

	localparam logic [30:0] REP_MAX = 31'h7FFF_FFFF;

	typedef struct packed {
		logic       start;
		logic [1:0] op;
		logic [7:0] n;
	} unit_cmd_t;

endpackage
`default_nettype wire

FILE: design/pfps_unit.sv
`default_nettype none
// iterative multiply / divide / square root around one add-subtract
module pfps_unit import pfps_pkg::*; (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire unit_cmd_t     cmd,
	input  wire logic [UW-1:0] init_a,
	input  wire logic [UW-1:0] opa_in,
	input  wire logic [UW-1:0] opb_in,
	output logic      [UW-1:0] res,
	output logic      [UW-1:0] quo,
	output logic      [UW-1:0] root,
	output logic               done
);

	logic [UW-1:0] acc_q, opa_q, opb_q, quo_q;
	logic [7:0]    cnt_q;
	logic [1:0]    op_q;
	logic          busy_q, done_q;
	logic [UW-1:0] x, y;
	logic          sub;
	logic [UW:0]   sum;
	logic          ge;

	always_comb begin
		case (op_q)
			OP_DIV: begin
				x   = {acc_q[UW-2:0], opb_q[UW-1]};
				y   = opa_q;
				sub = 1'b1;
			end
			OP_SQRT: begin
				x   = acc_q;
				y   = opa_q | opb_q;
				sub = 1'b1;
			end
			default: begin
				x   = acc_q;
				y   = opa_q;
				sub = 1'b0;
			end
		endcase
		sum = {1'b0, x} + {1'b0, y ^ {UW{sub}}} + {{UW{1'b0}}, sub};
		ge  = sum[UW];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
			op_q   <= OP_MUL;
			acc_q  <= '0;
			opa_q  <= '0;
			opb_q  <= '0;
			quo_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (cmd.start) begin
				acc_q  <= init_a;
				opa_q  <= opa_in;
				opb_q  <= opb_in;
				quo_q  <= '0;
				cnt_q  <= cmd.n;
				op_q   <= cmd.op;
				busy_q <= 1'b1;
			end else if (busy_q) begin
				case (op_q)
					OP_DIV: begin
						acc_q <= ge ? sum[UW-1:0] : x;
						quo_q <= {quo_q[UW-2:0], ge};
						opb_q <= {opb_q[UW-2:0], 1'b0};
					end
					OP_SQRT: begin
						if (ge) begin
							acc_q <= sum[UW-1:0];
							opa_q <= (opa_q >> 1) | opb_q;
						end else begin
							opa_q <= opa_q >> 1;
						end
						opb_q <= opb_q >> 2;
					end
					default: begin
						if (opb_q[0])
							acc_q <= sum[UW-1:0];
						opa_q <= {opa_q[UW-2:0], 1'b0};
						opb_q <= opb_q >> 1;
					end
				endcase
				cnt_q <= cnt_q - 8'd1;
				if (cnt_q == 8'd1) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	assign res  = acc_q;
	assign quo  = quo_q;
	assign root = opa_q;
	assign done = done_q;

endmodule
`default_nettype wire

FILE: design/potential_field_position_step.sv
`default_nettype none
// Potential-field position stepper.
// Input channel (in_valid/in_stall): opcode, start_x, start_y. Opcode 1 loads
// the position; opcode 0 moves it one gradient step (attraction toward the
// target plus repulsion from obstacles inside the influence radius).
// Output channel (out_valid/out_stall): next_x, next_y, repelling_mask,
// saturated; one result beat per input beat.
// Config channel (cfg_valid/cfg_ready, always ready): cfg_index selects
// target_x, target_y, influence_radius, attract_gain, repulse_gain and the
// three obstacles; write only while idle.
// Flow: one item at a time through a single shared multiply/divide/sqrt
// unit (one bit per cycle). A load goes via ST_OUT to the output register.
// A step runs attraction, plus per obstacle inside the radius two squarings,
// a square root, three divides and four multiplies (the two repulsion divides
// dominate); an obstacle outside the bounding square ends at the square test,
// one inside the square but outside the circle at the square root.
// in_stall is high while an item is in work; a finished result sits in the
// output register, so a new beat is taken while it waits. If the output is
// still stalled when the next result is ready, the sequencer holds.
// Reset: position 0,0, registers at their defaults, no output valid.
module potential_field_position_step import pfps_pkg::*; #(
	parameter int NUM_OBSTACLES = 3,
	parameter int FRAC_BITS     = 20
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        in_valid,
	output logic             in_stall,
	input  wire logic        opcode,
	input  wire logic [31:0] start_x,
	input  wire logic [31:0] start_y,
	output logic             out_valid,
	input  wire logic        out_stall,
	output logic      [31:0] next_x,
	output logic      [31:0] next_y,
	output logic      [2:0]  repelling_mask,
	output logic             saturated,
	input  wire logic        cfg_valid,
	output logic             cfg_ready,
	input  wire logic [2:0]  cfg_index,
	input  wire logic [63:0] cfg_data
);

	localparam int SH = 4 * FRAC_BITS - 32;

	localparam logic [4:0] ST_IDLE  = 5'd0;
	localparam logic [4:0] ST_OBS   = 5'd1;
	localparam logic [4:0] ST_SQX   = 5'd2;
	localparam logic [4:0] ST_SQY   = 5'd3;
	localparam logic [4:0] ST_ROOT  = 5'd4;
	localparam logic [4:0] ST_FDIV  = 5'd5;
	localparam logic [4:0] ST_AMUL  = 5'd6;
	localparam logic [4:0] ST_DEN   = 5'd7;
	localparam logic [4:0] ST_NUMX  = 5'd8;
	localparam logic [4:0] ST_DIVX  = 5'd9;
	localparam logic [4:0] ST_NUMY  = 5'd10;
	localparam logic [4:0] ST_DIVY  = 5'd11;
	localparam logic [4:0] ST_ATTX  = 5'd12;
	localparam logic [4:0] ST_ATTY  = 5'd13;
	localparam logic [4:0] ST_OUT   = 5'd14;

	// config registers
	logic [31:0] tx_q, ty_q, ka_q, kr_q;
	logic [30:0] r_q;
	logic [63:0] obs_q [3];

	// sequencer state
	logic [4:0]         state_q;
	logic               issued_q;
	logic [1:0]         j_q;
	logic [31:0]        px_q, py_q;
	logic [30:0]        ax_q, ay_q;
	logic               sx_q, sy_q;
	logic [62:0]        d2_q;
	logic [31:0]        d_q;
	logic [32:0]        f_q;
	logic [31:0]        amag_q;
	logic [123:0]       den_q;
	logic [62:0]        prod_q;
	logic signed [34:0] rx_q, ry_q;
	logic [2:0]         mask_q;
	logic               sat_q;
	logic [31:0]        nx_q, ny_q;

	// output register
	logic        out_valid_q;
	logic [31:0] out_x_q, out_y_q;
	logic [2:0]  out_mask_q;
	logic        out_sat_q;

	// shared unit
	unit_cmd_t  cmd;
	logic [UW-1:0] ua, ub, uc, u_res, u_quo, u_root;
	logic       u_done;

	pfps_unit u_unit (
		.clk    (clk),
		.arst_n (arst_n),
		.cmd    (cmd),
		.init_a (ua),
		.opa_in (ub),
		.opb_in (uc),
		.res    (u_res),
		.quo    (u_quo),
		.root   (u_root),
		.done   (u_done)
	);

	// obstacle offsets
	logic [63:0]        ob;
	logic signed [32:0] dx, dy;
	logic [32:0]        adx, ady;
	assign ob  = obs_q[j_q];
	assign dx  = $signed({ob[31], ob[31:0]}) - $signed({px_q[31], px_q});
	assign dy  = $signed({ob[63], ob[63:32]}) - $signed({py_q[31], py_q});
	assign adx = dx[32] ? 33'(-dx) : 33'(dx);
	assign ady = dy[32] ? 33'(-dy) : 33'(dy);

	// attraction error for the axis in work
	logic               att_y;
	logic signed [32:0] e;
	logic [32:0]        ae;
	assign att_y = (state_q == ST_ATTY);
	assign e  = att_y ? $signed({py_q[31], py_q}) - $signed({ty_q[31], ty_q})
	                  : $signed({px_q[31], px_q}) - $signed({tx_q[31], tx_q});
	assign ae = e[32] ? 33'(-e) : 33'(e);

	logic arith;
	always_comb begin
		case (state_q)
			ST_SQX, ST_SQY, ST_ROOT, ST_FDIV, ST_AMUL, ST_DEN,
			ST_NUMX, ST_DIVX, ST_NUMY, ST_DIVY, ST_ATTX, ST_ATTY: arith = 1'b1;
			default: arith = 1'b0;
		endcase
	end

	always_comb begin
		cmd       = '0;
		cmd.start = arith && !issued_q;
		ua = '0;
		ub = '0;
		uc = '0;
		case (state_q)
			ST_SQX: begin
				cmd.op = OP_MUL; cmd.n = 8'd31;
				ub = UW'(ax_q); uc = UW'(ax_q);
			end
			ST_SQY: begin
				// accumulate on top of dx^2
				cmd.op = OP_MUL; cmd.n = 8'd31;
				ua = u_res; ub = UW'(ay_q); uc = UW'(ay_q);
			end
			ST_ROOT: begin
				cmd.op = OP_SQRT; cmd.n = 8'd32;
				ua = UW'(d2_q); uc = UW'(1) << 62;
			end
			ST_FDIV: begin
				cmd.op = OP_DIV; cmd.n = 8'd64;
				ub = UW'(r_q);
				uc = UW'(32'({1'b0, r_q}) - d_q) << 96;
			end
			ST_AMUL: begin
				cmd.op = OP_MUL; cmd.n = 8'd33;
				ub = UW'(kr_q); uc = UW'(f_q);
			end
			ST_DEN: begin
				cmd.op = OP_MUL; cmd.n = 8'd62;
				ub = UW'(d2_q); uc = UW'(d2_q);
			end
			ST_NUMX: begin
				cmd.op = OP_MUL; cmd.n = 8'd31;
				ub = UW'(amag_q); uc = UW'(ax_q);
			end
			ST_NUMY: begin
				cmd.op = OP_MUL; cmd.n = 8'd31;
				ub = UW'(amag_q); uc = UW'(ay_q);
			end
			ST_DIVX, ST_DIVY: begin
				cmd.op = OP_DIV; cmd.n = 8'd128;
				ub = UW'(den_q); uc = UW'(prod_q) << SH;
			end
			ST_ATTX, ST_ATTY: begin
				// 2^31 preload rounds halves away from zero
				cmd.op = OP_MUL; cmd.n = 8'd33;
				ua = UW'(1) << 31; ub = UW'(ka_q); uc = UW'(ae);
			end
			default: begin
				cmd.op = OP_MUL;
			end
		endcase
	end

	// repulsion quotient with saturation
	logic        q_over;
	logic [30:0] q_term;
	assign q_over = |u_quo[UW-1:31];
	assign q_term = q_over ? REP_MAX : u_quo[30:0];

	logic signed [34:0] term_x, term_y;
	assign term_x = sx_q ? -$signed({4'b0, q_term}) : $signed({4'b0, q_term});
	assign term_y = sy_q ? -$signed({4'b0, q_term}) : $signed({4'b0, q_term});

	// new coordinate, exact then clamped
	logic [33:0]        a_mag;
	logic signed [37:0] a_s, p_s, r_s, n_full;
	logic               n_hi, n_lo;
	logic [31:0]        n_clamp;
	assign a_mag = u_res[65:32];
	assign a_s   = e[32] ? -$signed({4'b0, a_mag}) : $signed({4'b0, a_mag});
	assign p_s   = att_y ? 38'($signed(py_q)) : 38'($signed(px_q));
	assign r_s   = att_y ? 38'(ry_q) : 38'(rx_q);
	assign n_full = p_s - a_s - r_s;
	assign n_hi  = n_full > 38'sd2147483647;
	assign n_lo  = n_full < -38'sd2147483648;
	assign n_clamp = n_hi ? 32'h7FFF_FFFF : (n_lo ? 32'h8000_0000 : n_full[31:0]);

	logic last_obs;
	assign last_obs = (j_q == 2'(NUM_OBSTACLES - 1));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			issued_q    <= 1'b0;
			j_q         <= '0;
			px_q        <= '0;
			py_q        <= '0;
			rx_q        <= '0;
			ry_q        <= '0;
			mask_q      <= '0;
			sat_q       <= 1'b0;
			out_valid_q <= 1'b0;
			tx_q        <= 32'd10485760;
			ty_q        <= 32'd10485760;
			r_q         <= 31'd3145728;
			ka_q        <= 32'd171799;
			kr_q        <= 32'd85899;
			obs_q[0]    <= 64'd11258999070523392;
			obs_q[1]    <= 64'd22517998143143936;
			obs_q[2]    <= 64'd36028797027352576;
		end else begin
			if (cfg_valid) begin
				case (cfg_index)
					CFG_TARGET_X: tx_q     <= cfg_data[31:0];
					CFG_TARGET_Y: ty_q     <= cfg_data[31:0];
					CFG_RADIUS:   r_q      <= cfg_data[30:0];
					CFG_KA:       ka_q     <= cfg_data[31:0];
					CFG_KR:       kr_q     <= cfg_data[31:0];
					CFG_OBS0:     obs_q[0] <= cfg_data;
					CFG_OBS1:     obs_q[1] <= cfg_data;
					CFG_OBS2:     obs_q[2] <= cfg_data;
					default: ;
				endcase
			end

			// ST_OUT refills the output register itself
			if (out_valid_q && !out_stall && state_q != ST_OUT)
				out_valid_q <= 1'b0;

			if (cmd.start)
				issued_q <= 1'b1;
			if (u_done)
				issued_q <= 1'b0;

			case (state_q)
				ST_IDLE: begin
					if (in_valid) begin
						j_q    <= '0;
						rx_q   <= '0;
						ry_q   <= '0;
						mask_q <= '0;
						sat_q  <= 1'b0;
						if (opcode) begin
							nx_q    <= start_x;
							ny_q    <= start_y;
							state_q <= ST_OUT;
						end else begin
							state_q <= ST_OBS;
						end
					end
				end
				ST_OBS: begin
					ax_q <= adx[30:0];
					ay_q <= ady[30:0];
					sx_q <= dx[32];
					sy_q <= dy[32];
					if (adx >= {2'b0, r_q} || ady >= {2'b0, r_q}) begin
						j_q <= j_q + 2'd1;
						if (last_obs)
							state_q <= ST_ATTX;
					end else begin
						state_q <= ST_SQX;
					end
				end
				ST_SQX: begin
					if (u_done) state_q <= ST_SQY;
				end
				ST_SQY: begin
					if (u_done) begin
						d2_q    <= u_res[62:0];
						state_q <= ST_ROOT;
					end
				end
				ST_ROOT: begin
					if (u_done) begin
						d_q <= u_root[31:0];
						if (u_root[31:0] >= {1'b0, r_q}) begin
							j_q     <= j_q + 2'd1;
							state_q <= last_obs ? ST_ATTX : ST_OBS;
						end else begin
							mask_q[j_q] <= 1'b1;
							if (d2_q == '0) begin
								// coincident obstacle
								sat_q   <= 1'b1;
								rx_q    <= rx_q + 35'sd2147483647;
								ry_q    <= ry_q + 35'sd2147483647;
								j_q     <= j_q + 2'd1;
								state_q <= last_obs ? ST_ATTX : ST_OBS;
							end else begin
								state_q <= ST_FDIV;
							end
						end
					end
				end
				ST_FDIV: begin
					if (u_done) begin
						f_q     <= u_quo[32:0];
						state_q <= ST_AMUL;
					end
				end
				ST_AMUL: begin
					if (u_done) begin
						amag_q  <= u_res[63:32];
						state_q <= ST_DEN;
					end
				end
				ST_DEN: begin
					if (u_done) begin
						den_q   <= u_res[123:0];
						state_q <= ST_NUMX;
					end
				end
				ST_NUMX: begin
					if (u_done) begin
						prod_q  <= u_res[62:0];
						state_q <= ST_DIVX;
					end
				end
				ST_DIVX: begin
					if (u_done) begin
						rx_q    <= rx_q + term_x;
						if (q_over) sat_q <= 1'b1;
						state_q <= ST_NUMY;
					end
				end
				ST_NUMY: begin
					if (u_done) begin
						prod_q  <= u_res[62:0];
						state_q <= ST_DIVY;
					end
				end
				ST_DIVY: begin
					if (u_done) begin
						ry_q    <= ry_q + term_y;
						if (q_over) sat_q <= 1'b1;
						j_q     <= j_q + 2'd1;
						state_q <= last_obs ? ST_ATTX : ST_OBS;
					end
				end
				ST_ATTX: begin
					if (u_done) begin
						nx_q    <= n_clamp;
						if (n_hi || n_lo) sat_q <= 1'b1;
						state_q <= ST_ATTY;
					end
				end
				ST_ATTY: begin
					if (u_done) begin
						ny_q    <= n_clamp;
						if (n_hi || n_lo) sat_q <= 1'b1;
						state_q <= ST_OUT;
					end
				end
				ST_OUT: begin
					if (!out_valid_q || !out_stall) begin
						out_valid_q <= 1'b1;
						out_x_q     <= nx_q;
						out_y_q     <= ny_q;
						out_mask_q  <= mask_q;
						out_sat_q   <= sat_q;
						px_q        <= nx_q;
						py_q        <= ny_q;
						state_q     <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	assign in_stall       = (state_q != ST_IDLE);
	assign cfg_ready      = 1'b1;
	assign out_valid      = out_valid_q;
	assign next_x         = out_x_q;
	assign next_y         = out_y_q;
	assign repelling_mask = out_mask_q;
	assign saturated      = out_sat_q;

endmodule
`default_nettype wire

FILE: tb/potential_field_position_step_tb.sv
`default_nettype none
module potential_field_position_step_tb;
	import pfps_pkg::*;

	localparam int FRAC          = 20;
	localparam int NOBS          = 3;
	localparam int CYCLE_LIMIT   = 8_000_000;
	localparam int DRAIN_CYCLES  = 40;
	localparam logic [63:0] REP_LIM = 64'h7FFF_FFFF;

	// one result beat as the block presents it
	typedef struct packed {
		logic [31:0] x;
		logic [31:0] y;
		logic [2:0]  mask;
		logic        sat;
	} step_result_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        in_valid = 1'b0;
	logic        in_stall;
	logic        opcode = 1'b0;
	logic [31:0] start_x = '0;
	logic [31:0] start_y = '0;
	logic        out_valid;
	logic        out_stall = 1'b0;
	logic [31:0] next_x;
	logic [31:0] next_y;
	logic [2:0]  repelling_mask;
	logic        saturated;
	logic        cfg_valid = 1'b0;
	logic        cfg_ready;
	logic [2:0]  cfg_index = '0;
	logic [63:0] cfg_data = '0;

	potential_field_position_step #(
		.NUM_OBSTACLES(NOBS),
		.FRAC_BITS(FRAC)
	) dut (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_stall(in_stall),
		.opcode(opcode), .start_x(start_x), .start_y(start_y),
		.out_valid(out_valid), .out_stall(out_stall),
		.next_x(next_x), .next_y(next_y),
		.repelling_mask(repelling_mask), .saturated(saturated),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
		.cfg_index(cfg_index), .cfg_data(cfg_data)
	);

	always begin
		clk = 1'b1;
		#10;
		clk = 1'b0;
		#10;
	end

	// Shadow copy of the register file and the tracked position.
	logic [31:0] goal_x, goal_y, gain_att, gain_rep;
	logic [30:0] radius;
	logic [63:0] obst [NOBS];
	logic [31:0] cur_x, cur_y;

	step_result_t pending_pos[$];

	int unsigned errors     = 0;
	int unsigned beats_in   = 0;
	int unsigned beats_out  = 0;
	int unsigned repel_hits = 0;
	int unsigned sat_hits   = 0;
	int unsigned cycles     = 0;
	bit          idle_on    = 1'b1;
	bit          long_hold  = 1'b0;
	int unsigned hold_cnt   = 0;
	int unsigned burst_out  = 0;

	function automatic logic [63:0] floor_sqrt(input logic [63:0] v);
		logic [63:0] res;
		logic [63:0] bv;
		res = '0;
		bv = 64'h1 << 62;
		while (bv > v)
			bv = bv >> 2;
		while (bv != 0) begin
			if (v >= res + bv) begin
				v = v - (res + bv);
				res = (res >> 1) + bv;
			end else begin
				res = res >> 1;
			end
			bv = bv >> 2;
		end
		return res;
	endfunction

	// kr-scaled push along one axis: A*|off|*2^(4F-32)/d2^2, clamped to 31 bits
	function automatic logic [63:0] push_mag(input logic [63:0] amag, input logic [63:0] off,
			input logic [63:0] d2, output bit clipped);
		logic [127:0] num, den, q;
		clipped = 1'b0;
		if (d2 == 0) begin
			clipped = 1'b1;
			return REP_LIM;
		end
		num = {64'h0, amag * off} << (4 * FRAC - 32);
		den = {64'h0, d2} * {64'h0, d2};
		q = num / den;
		if (q > {64'h0, REP_LIM}) begin
			clipped = 1'b1;
			return REP_LIM;
		end
		return q[63:0];
	endfunction

	// rounded attraction: sign(e)*((ka*|e| + 2^31) >> 32), as the hardware computes it
	function automatic longint pull(input longint p, input longint t, input logic [31:0] ka);
		longint      e;
		logic [63:0] m, a;
		e = p - t;
		m = (e < 0) ? 64'(-e) : 64'(e);
		a = ({32'h0, ka} * m + 64'h8000_0000) >> 32;
		return (e < 0) ? -longint'(a) : longint'(a);
	endfunction

	function automatic longint clamp_pos(input longint v, inout bit sat);
		if (v > 64'sd2147483647) begin
			sat = 1'b1;
			return 64'sd2147483647;
		end
		if (v < -64'sd2147483648) begin
			sat = 1'b1;
			return -64'sd2147483648;
		end
		return v;
	endfunction

	// Predicts one beat and updates the tracked position.
	function automatic step_result_t predict_position(input logic op, input logic [31:0] sx,
			input logic [31:0] sy);
		step_result_t res;
		longint       px, py, dx, dy, rx, ry, nx, ny;
		logic [63:0]  ax, ay, d2, d, f, amag, qx, qy, r;
		bit           sat, c;
		int           j;
		res = '0;
		if (op) begin
			cur_x = sx;
			cur_y = sy;
			res.x = sx;
			res.y = sy;
			return res;
		end
		px = longint'($signed(cur_x));
		py = longint'($signed(cur_y));
		rx = 0;
		ry = 0;
		sat = 1'b0;
		r = {33'h0, radius};
		for (j = 0; j < NOBS; j++) begin
			dx = longint'($signed(obst[j][31:0])) - px;
			dy = longint'($signed(obst[j][63:32])) - py;
			ax = (dx < 0) ? 64'(-dx) : 64'(dx);
			ay = (dy < 0) ? 64'(-dy) : 64'(dy);
			if (ax >= r || ay >= r)
				continue;
			d2 = ax * ax + ay * ay;
			if (d2 >= r * r)
				continue;
			res.mask[j] = 1'b1;
			d = floor_sqrt(d2);
			f = ((r - d) << 32) / r;
			amag = ({32'h0, gain_rep} * f) >> 32;
			qx = push_mag(amag, ax, d2, c);
			sat |= c;
			qy = push_mag(amag, ay, d2, c);
			sat |= c;
			rx += (dx < 0) ? -longint'(qx) : longint'(qx);
			ry += (dy < 0) ? -longint'(qy) : longint'(qy);
		end
		nx = clamp_pos(px - pull(px, longint'($signed(goal_x)), gain_att) - rx, sat);
		ny = clamp_pos(py - pull(py, longint'($signed(goal_y)), gain_att) - ry, sat);
		cur_x = nx[31:0];
		cur_y = ny[31:0];
		res.x = cur_x;
		res.y = cur_y;
		res.sat = sat;
		return res;
	endfunction

	// Runaway guard.
	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("timeout after %0d cycles, %0d results outstanding", cycles,
				pending_pos.size());
			$display("potential_field_position_step regression: fail");
			$finish;
		end
	end

	// Receiver: random stall bursts, plus an occasional long hold-off requested by a test.
	always @(negedge clk) begin
		if (long_hold) begin
			long_hold = 1'b0;
			hold_cnt = 400;
		end
		if (hold_cnt > 0) begin
			hold_cnt--;
			out_stall = 1'b1;
		end else if (burst_out > 0) begin
			burst_out--;
			out_stall = 1'b1;
		end else begin
			out_stall = 1'b0;
			if (idle_on && $urandom_range(0, 7) == 0)
				burst_out = $urandom_range(1, 11);
		end
	end

	// Result checker: each accepted beat against the oldest prediction.
	always @(posedge clk) begin
		step_result_t exp_r;
		if (arst_n && out_valid && !out_stall) begin
			beats_out++;
			if (pending_pos.size() == 0) begin
				$display("%0t: unexpected result beat x=%h y=%h mask=%b sat=%b", $time,
					next_x, next_y, repelling_mask, saturated);
				errors++;
			end else begin
				exp_r = pending_pos.pop_front();
				if (repelling_mask != 0)
					repel_hits++;
				if (saturated)
					sat_hits++;
				if (next_x !== exp_r.x) begin
					$display("%0t: next_x expected %h actual %h", $time, exp_r.x, next_x);
					errors++;
				end
				if (next_y !== exp_r.y) begin
					$display("%0t: next_y expected %h actual %h", $time, exp_r.y, next_y);
					errors++;
				end
				if (repelling_mask !== exp_r.mask) begin
					$display("%0t: repelling_mask expected %b actual %b", $time, exp_r.mask,
						repelling_mask);
					errors++;
				end
				if (saturated !== exp_r.sat) begin
					$display("%0t: saturated expected %b actual %b", $time, exp_r.sat,
						saturated);
					errors++;
				end
			end
		end
	end

	// Offers one beat; returns at the falling edge after acceptance.
	task automatic send_item(input logic op, input logic [31:0] sx, input logic [31:0] sy);
		if (idle_on && $urandom_range(0, 5) == 0) begin
			in_valid = 1'b0;
			repeat ($urandom_range(1, 11)) @(negedge clk);
		end
		in_valid = 1'b1;
		opcode = op;
		start_x = sx;
		start_y = sy;
		do
			@(posedge clk);
		while (in_stall);
		pending_pos.push_back(predict_position(op, sx, sy));
		beats_in++;
		@(negedge clk);
		in_valid = 1'b0;
	endtask

	task automatic load_pos(input logic [31:0] sx, input logic [31:0] sy);
		send_item(1'b1, sx, sy);
	endtask

	task automatic step_pos(input int n);
		repeat (n) send_item(1'b0, $urandom(), $urandom());
	endtask

	// Waits out every outstanding result, then idles before returning.
	task automatic drain();
		while (pending_pos.size() != 0)
			@(negedge clk);
		repeat (8) @(negedge clk);
	endtask

	task automatic write_reg(input logic [2:0] idx, input logic [63:0] val);
		cfg_valid = 1'b1;
		cfg_index = idx;
		cfg_data = val;
		do
			@(posedge clk);
		while (!cfg_ready);
		case (idx)
			CFG_TARGET_X: goal_x = val[31:0];
			CFG_TARGET_Y: goal_y = val[31:0];
			CFG_RADIUS:   radius = val[30:0];
			CFG_KA:       gain_att = val[31:0];
			CFG_KR:       gain_rep = val[31:0];
			CFG_OBS0:     obst[0] = val;
			CFG_OBS1:     obst[1] = val;
			CFG_OBS2:     obst[2] = val;
			default: ;
		endcase
		@(negedge clk);
		cfg_valid = 1'b0;
	endtask

	function automatic logic [31:0] units(input int v);
		return 32'(v <<< FRAC);
	endfunction

	// Random coordinate within +/- span units.
	function automatic logic [31:0] rand_coord(input int span);
		return 32'($urandom_range(0, 2 * (span << FRAC)) - (span << FRAC));
	endfunction

	// Loads, steps, extremes and the special cases, starting from the reset settings.
	task automatic test_directed();
		step_pos(2);                              // from origin, all obstacles outside
		load_pos(obst[0][31:0], obst[0][63:32]);  // coincident obstacle
		step_pos(1);
		load_pos(units(2) + 32'h8_0000, units(2) + 32'h8_0000);
		step_pos(3);
		load_pos(32'h7FFF_FFFF, 32'h8000_0000);
		step_pos(1);
		load_pos(32'h8000_0000, 32'h7FFF_FFFF);
		step_pos(1);
		drain();
		// zero radius: nothing repels even on top of an obstacle
		write_reg(CFG_RADIUS, 64'h0);
		load_pos(obst[1][31:0], obst[1][63:32]);
		step_pos(1);
		drain();
		// extreme gains and far targets drive the position clamp
		write_reg(CFG_RADIUS, 64'h7FFF_FFFF);
		write_reg(CFG_KA, 64'hFFFF_FFFF);
		write_reg(CFG_KR, 64'hFFFF_FFFF);
		write_reg(CFG_TARGET_X, 64'h7FFF_FFFF);
		write_reg(CFG_TARGET_Y, 64'h8000_0000);
		load_pos(32'h8000_0000, 32'h7FFF_FFFF);
		step_pos(2);
		load_pos(units(5), units(4));
		step_pos(1);
		drain();
		write_reg(CFG_KA, 64'h0);
		write_reg(CFG_KR, 64'h0);
		load_pos(units(3), units(3));
		step_pos(1);
		drain();
	endtask

	// Random settings: moderate with obstacles in a small arena, or wild over the full range.
	task automatic random_settings(input bit wild);
		int j;
		write_reg(CFG_TARGET_X, {32'h0, rand_coord(12)});
		write_reg(CFG_TARGET_Y, {32'h0, rand_coord(12)});
		write_reg(CFG_RADIUS, wild ? {33'h0, 31'($urandom())} :
			64'($urandom_range(1 << (FRAC - 2), 5 << FRAC)));
		write_reg(CFG_KA, $urandom_range(0, 3) == 0 ? {32'h0, $urandom()} :
			64'($urandom_range(0, 32'h1000_0000)));
		write_reg(CFG_KR, {32'h0, $urandom()});
		for (j = 0; j < NOBS; j++)
			write_reg(3'(CFG_OBS0 + j), wild ? {$urandom(), $urandom()} :
				{rand_coord(8), rand_coord(8)});
	endtask

	// Mostly load-near-an-obstacle followed by a short walk; the rest is noise.
	task automatic test_random_walk(input int n);
		int          target;
		int          j;
		int          span;
		logic [31:0] off_x, off_y;
		target = beats_in + n;
		while (beats_in < target) begin
			if ($urandom_range(0, 9) < 7) begin
				j = $urandom_range(0, NOBS - 1);
				span = (radius > (8 << FRAC)) ? (8 << FRAC) : int'(radius);
				off_x = 32'($urandom_range(0, 2 * span) - span);
				off_y = 32'($urandom_range(0, 2 * span) - span);
				load_pos(obst[j][31:0] + off_x, obst[j][63:32] + off_y);
				step_pos($urandom_range(1, 6));
			end else if ($urandom_range(0, 1) == 0) begin
				load_pos($urandom(), $urandom());
			end else begin
				step_pos(1);
			end
		end
		drain();
	endtask

	// Receiver holds off long while the sender keeps offering, so the block backs up.
	task automatic test_backpressure();
		write_reg(CFG_RADIUS, 64'h0);
		long_hold = 1'b1;
		@(negedge clk);
		load_pos(units(1), units(-1));
		step_pos(5);
		drain();
		// then the sender pauses between items until each result is back
		repeat (4) begin
			step_pos(1);
			drain();
		end
	endtask

	initial begin
		goal_x = 32'd10485760;
		goal_y = 32'd10485760;
		radius = 31'd3145728;
		gain_att = 32'd171799;
		gain_rep = 32'd85899;
		obst[0] = 64'd11258999070523392;
		obst[1] = 64'd22517998143143936;
		obst[2] = 64'd36028797027352576;
		cur_x = '0;
		cur_y = '0;
		arst_n = 1'b0;
		repeat (5) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		repeat (2) @(negedge clk);

		test_directed();
		test_backpressure();
		random_settings(1'b0);
		test_random_walk(250);
		random_settings(1'b1);
		test_random_walk(150);
		random_settings(1'b0);
		test_random_walk(250);
		random_settings(1'b0);
		test_random_walk(200);
		// closing stretch with both sides always ready
		idle_on = 1'b0;
		random_settings(1'b0);
		test_random_walk(180);

		drain();
		repeat (DRAIN_CYCLES) @(negedge clk);
		$display("%0d beats sent, %0d results checked over %0d cycles", beats_in, beats_out,
			cycles);
		$display("%0d results inside an obstacle radius, %0d with clamping", repel_hits,
			sat_hits);
		if (errors == 0 && pending_pos.size() == 0) begin
			$display("potential_field_position_step regression: pass");
		end else begin
			$display("%0d mismatches, %0d results missing", errors, pending_pos.size());
			$display("potential_field_position_step regression: fail");
		end
		$finish;
	end

endmodule
`default_nettype wire
